/* rtl/i2cseq_pkg.sv */
// Shared types and codes for the I2C master transaction sequencer.
// Holds bus action codes, bus engine status codes and the item structs.
// No dependencies.
package i2cseq_pkg;

    // bus actions handed to the byte-level engine
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_SEND    = 3'd2;
    localparam logic [2:0] ACT_RX_ACK  = 3'd3;
    localparam logic [2:0] ACT_RX_NACK = 3'd4;
    localparam logic [2:0] ACT_STOP    = 3'd5;

    // item kinds on the input channel
    localparam logic OP_BEGIN  = 1'b0;
    localparam logic OP_STATUS = 1'b1;

    // bus engine status codes, low three bits masked
    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK = 8'h48;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;
    localparam logic [7:0] ST_IDLE      = 8'hF8;

    // byte count reported on failure
    localparam logic [7:0] COUNT_ERROR = 8'hFF;

    typedef struct packed {
        logic        op;
        logic [7:0]  device_address;
        logic [15:0] mem_address;
        logic [1:0]  address_bytes;
        logic        is_read;
        logic [6:0]  byte_length;
        logic [7:0]  status_code;
        logic [7:0]  rx_data;
        logic [7:0]  tx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_value;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       done_res;
        logic [7:0] byte_count;
    } result_t;

endpackage

/* rtl/i2cseq_fsm.sv */
// Transaction state and next-action decision for the I2C sequencer.
// One item in, one result out, state advanced on the fire strobe.
// Depends on i2cseq_pkg.
module i2cseq_fsm #(
    parameter int MAX_LENGTH = 127
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  i2cseq_pkg::item_t    item,
    input  logic [7:0]           max_attempts,
    output i2cseq_pkg::result_t  res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_SLAW, PH_ADDR, PH_RSTART, PH_SLAR, PH_RX, PH_TX
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  attempts_reg, attempts_next;
    logic [6:0]  remaining_reg, remaining_next;
    logic [6:0]  transferred_reg, transferred_next;
    logic        addr_index_reg, addr_index_next;
    logic [7:0]  dev_reg, dev_next;
    logic [15:0] mem_reg, mem_next;
    logic        rd_reg, rd_next;
    logic        two_reg, two_next;

    logic [7:0]  len_sat;
    logic [7:0]  max_len;
    logic [6:0]  rem_dec;
    logic [6:0]  xfer_inc;
    logic [2:0]  rx_act_now;
    logic [2:0]  rx_act_dec;

    assign max_len    = 8'(MAX_LENGTH);
    assign len_sat    = ({1'b0, item.byte_length} > max_len) ? max_len
                                                             : {1'b0, item.byte_length};
    assign rem_dec    = (remaining_reg != 7'd0) ? remaining_reg - 7'd1 : 7'd0;
    assign xfer_inc   = transferred_reg + 7'd1;
    assign rx_act_now = (remaining_reg > 7'd1) ? i2cseq_pkg::ACT_RX_ACK
                                               : i2cseq_pkg::ACT_RX_NACK;
    assign rx_act_dec = (rem_dec > 7'd1) ? i2cseq_pkg::ACT_RX_ACK
                                         : i2cseq_pkg::ACT_RX_NACK;

    always_comb begin
        phase_next       = phase_reg;
        attempts_next    = attempts_reg;
        remaining_next   = remaining_reg;
        transferred_next = transferred_reg;
        addr_index_next  = addr_index_reg;
        dev_next         = dev_reg;
        mem_next         = mem_reg;
        rd_next          = rd_reg;
        two_next         = two_reg;
        res              = '0;
        res.action       = i2cseq_pkg::ACT_NONE;

        if (item.op == i2cseq_pkg::OP_BEGIN) begin
            // latch the request and make the first attempt
            dev_next         = item.device_address;
            mem_next         = item.mem_address;
            rd_next          = item.is_read;
            two_next         = item.address_bytes[1];
            remaining_next   = len_sat[6:0];
            transferred_next = 7'd0;
            if (max_attempts == 8'd0) begin
                attempts_next  = 8'd0;
                phase_next     = PH_IDLE;
                res.done_res   = 1'b1;
                res.byte_count = i2cseq_pkg::COUNT_ERROR;
            end else begin
                attempts_next   = 8'd1;
                phase_next      = PH_START;
                addr_index_next = 1'b0;
                res.action      = i2cseq_pkg::ACT_START;
            end
        end else begin
            case (phase_reg)
                PH_START: begin
                    if (item.status_code inside {i2cseq_pkg::ST_START,
                                                 i2cseq_pkg::ST_REP_START}) begin
                        phase_next   = PH_SLAW;
                        res.action   = i2cseq_pkg::ACT_SEND;
                        res.tx_value = {dev_reg[7:1], 1'b0};
                    end else if (item.status_code == i2cseq_pkg::ST_ARB_LOST) begin
                        addr_index_next = 1'b0;
                        res.action      = i2cseq_pkg::ACT_START;
                    end else begin
                        phase_next     = PH_IDLE;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                PH_SLAW: begin
                    if (item.status_code == i2cseq_pkg::ST_SLAW_ACK) begin
                        phase_next      = PH_ADDR;
                        addr_index_next = 1'b0;
                        res.action      = i2cseq_pkg::ACT_SEND;
                        res.tx_value    = two_reg ? mem_reg[15:8] : mem_reg[7:0];
                    end else if (item.status_code == i2cseq_pkg::ST_SLAW_NACK) begin
                        // retry while attempts remain, else fail without STOP
                        if (attempts_reg >= max_attempts) begin
                            phase_next     = PH_IDLE;
                            res.done_res   = 1'b1;
                            res.byte_count = i2cseq_pkg::COUNT_ERROR;
                        end else begin
                            attempts_next   = attempts_reg + 8'd1;
                            phase_next      = PH_START;
                            addr_index_next = 1'b0;
                            res.action      = i2cseq_pkg::ACT_START;
                        end
                    end else if (item.status_code == i2cseq_pkg::ST_ARB_LOST) begin
                        phase_next      = PH_START;
                        addr_index_next = 1'b0;
                        res.action      = i2cseq_pkg::ACT_START;
                    end else begin
                        phase_next     = PH_IDLE;
                        res.action     = i2cseq_pkg::ACT_STOP;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                PH_ADDR: begin
                    if (item.status_code == i2cseq_pkg::ST_DATA_ACK) begin
                        if (two_reg && !addr_index_reg) begin
                            addr_index_next = 1'b1;
                            res.action      = i2cseq_pkg::ACT_SEND;
                            res.tx_value    = mem_reg[7:0];
                        end else if (rd_reg) begin
                            phase_next = PH_RSTART;
                            res.action = i2cseq_pkg::ACT_START;
                        end else if (remaining_reg != 7'd0) begin
                            phase_next   = PH_TX;
                            res.action   = i2cseq_pkg::ACT_SEND;
                            res.tx_value = item.tx_byte;
                        end else begin
                            phase_next   = PH_IDLE;
                            res.action   = i2cseq_pkg::ACT_STOP;
                            res.done_res = 1'b1;
                        end
                    end else if (item.status_code == i2cseq_pkg::ST_DATA_NACK) begin
                        phase_next   = PH_IDLE;
                        res.action   = i2cseq_pkg::ACT_STOP;
                        res.done_res = 1'b1;
                    end else if (item.status_code == i2cseq_pkg::ST_ARB_LOST) begin
                        phase_next      = PH_START;
                        addr_index_next = 1'b0;
                        res.action      = i2cseq_pkg::ACT_START;
                    end else begin
                        phase_next     = PH_IDLE;
                        res.action     = i2cseq_pkg::ACT_STOP;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                PH_RSTART: begin
                    if (item.status_code inside {i2cseq_pkg::ST_START,
                                                 i2cseq_pkg::ST_REP_START}) begin
                        phase_next   = PH_SLAR;
                        res.action   = i2cseq_pkg::ACT_SEND;
                        res.tx_value = {dev_reg[7:1], 1'b1};
                    end else if (item.status_code == i2cseq_pkg::ST_ARB_LOST) begin
                        phase_next      = PH_START;
                        addr_index_next = 1'b0;
                        res.action      = i2cseq_pkg::ACT_START;
                    end else begin
                        phase_next     = PH_IDLE;
                        res.action     = i2cseq_pkg::ACT_STOP;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                PH_SLAR: begin
                    if (item.status_code == i2cseq_pkg::ST_SLAR_ACK) begin
                        if (remaining_reg != 7'd0) begin
                            phase_next = PH_RX;
                            res.action = rx_act_now;
                        end else begin
                            phase_next   = PH_IDLE;
                            res.action   = i2cseq_pkg::ACT_STOP;
                            res.done_res = 1'b1;
                        end
                    end else if (item.status_code == i2cseq_pkg::ST_SLAR_NACK) begin
                        phase_next   = PH_IDLE;
                        res.action   = i2cseq_pkg::ACT_STOP;
                        res.done_res = 1'b1;
                    end else if (item.status_code == i2cseq_pkg::ST_ARB_LOST) begin
                        phase_next      = PH_START;
                        addr_index_next = 1'b0;
                        res.action      = i2cseq_pkg::ACT_START;
                    end else begin
                        phase_next     = PH_IDLE;
                        res.action     = i2cseq_pkg::ACT_STOP;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                PH_RX: begin
                    if (item.status_code inside {i2cseq_pkg::ST_RX_ACK,
                                                 i2cseq_pkg::ST_RX_NACK}) begin
                        transferred_next = xfer_inc;
                        remaining_next   = rem_dec;
                        res.rx_valid     = 1'b1;
                        res.rx_byte      = item.rx_data;
                        if (item.status_code == i2cseq_pkg::ST_RX_NACK ||
                            rem_dec == 7'd0) begin
                            phase_next     = PH_IDLE;
                            res.action     = i2cseq_pkg::ACT_STOP;
                            res.done_res   = 1'b1;
                            res.byte_count = {1'b0, xfer_inc};
                        end else begin
                            res.action = rx_act_dec;
                        end
                    end else begin
                        phase_next     = PH_IDLE;
                        res.action     = i2cseq_pkg::ACT_STOP;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                PH_TX: begin
                    if (item.status_code == i2cseq_pkg::ST_DATA_ACK) begin
                        transferred_next = xfer_inc;
                        remaining_next   = rem_dec;
                        if (rem_dec != 7'd0) begin
                            res.action   = i2cseq_pkg::ACT_SEND;
                            res.tx_value = item.tx_byte;
                        end else begin
                            phase_next     = PH_IDLE;
                            res.action     = i2cseq_pkg::ACT_STOP;
                            res.done_res   = 1'b1;
                            res.byte_count = {1'b0, xfer_inc};
                        end
                    end else begin
                        phase_next     = PH_IDLE;
                        res.action     = i2cseq_pkg::ACT_STOP;
                        res.done_res   = 1'b1;
                        res.byte_count = i2cseq_pkg::COUNT_ERROR;
                    end
                end
                default: begin
                    // status while idle: no action
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            attempts_reg    <= 8'd0;
            remaining_reg   <= 7'd0;
            transferred_reg <= 7'd0;
            addr_index_reg  <= 1'b0;
            dev_reg         <= 8'd0;
            mem_reg         <= 16'd0;
            rd_reg          <= 1'b0;
            two_reg         <= 1'b0;
        end else if (fire) begin
            phase_reg       <= phase_next;
            attempts_reg    <= attempts_next;
            remaining_reg   <= remaining_next;
            transferred_reg <= transferred_next;
            addr_index_reg  <= addr_index_next;
            dev_reg         <= dev_next;
            mem_reg         <= mem_next;
            rd_reg          <= rd_next;
            two_reg         <= two_next;
        end
    end

    // a finished transaction always leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.done_res |=> phase_reg == PH_IDLE)
        else $error("phase not idle after done");

    // bytes moved plus bytes left never exceed 127
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, transferred_reg} + {1'b0, remaining_reg}) <= 8'd127)
        else $error("transfer count out of range");

    // a received byte is only reported with a receive or stop action
    a_rx_action: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.rx_valid |-> (res.action == i2cseq_pkg::ACT_RX_ACK ||
                                  res.action == i2cseq_pkg::ACT_RX_NACK ||
                                  res.action == i2cseq_pkg::ACT_STOP))
        else $error("rx byte with wrong action");

    // a second address byte is only pending in a two-byte address phase
    a_addr_index: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_index_reg && phase_reg == PH_ADDR |-> two_reg)
        else $error("second address byte without two-byte address");

endmodule

/* rtl/i2c_master_transaction_sequencer.sv */
// Top level of the I2C master register transaction sequencer.
// Input register, decision unit and result register; holds max_attempts.
// Depends on i2cseq_pkg and i2cseq_fsm.
//
//  channel   direction  handshake             beat carries
//  s_        in         s_tvalid / s_tready   begin request or engine status
//  m_        out        m_tvalid / m_tready   next bus action and results
//  cfg_      in         cfg_valid / cfg_ready max_attempts write
//
// Each beat passes two register stages: the input register takes it at the
// accepting edge and the decision logic fills the result register when the
// held beat advances, which waits while a stalled result is held.
// A new beat is accepted every cycle while the result side keeps draining.
// A stalled result holds the result register; the input register then
// holds the next beat, and s_tready drops only when both are full.
// Reset (aresetn low, synchronous) empties both stages, puts the sequencer
// idle and sets max_attempts to 20. cfg_ready stays high.
module i2c_master_transaction_sequencer #(
    parameter int MAX_LENGTH = 127
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] device_address, [23:8] mem_address, [25:24] address_bytes,
    // [26] is_read, [33:27] byte_length, [41:34] status_code,
    // [49:42] rx_data, [57:50] tx_byte, [63:58] zero
    input  logic [63:0] s_tdata,
    // [0] op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_value, [8] rx_valid, [16:9] rx_byte, [17] done_res,
    // [25:18] byte_count, [31:26] zero
    output logic [31:0] m_tdata,
    // [2:0] action
    output logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    i2cseq_pkg::item_t   in_item;
    i2cseq_pkg::item_t   in_item_reg;
    logic                in_valid_reg, in_valid_next;
    i2cseq_pkg::result_t res;
    i2cseq_pkg::result_t out_reg;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          max_attempts_reg;
    logic                s_accept;
    logic                advance;

    // unpack the slave beat
    always_comb begin
        in_item.op             = s_tuser;
        in_item.device_address = s_tdata[7:0];
        in_item.mem_address    = s_tdata[23:8];
        in_item.address_bytes  = s_tdata[25:24];
        in_item.is_read        = s_tdata[26];
        in_item.byte_length    = s_tdata[33:27];
        in_item.status_code    = s_tdata[41:34];
        in_item.rx_data        = s_tdata[49:42];
        in_item.tx_byte        = s_tdata[57:50];
    end

    // advance the held beat whenever the result register is free or draining
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_accept       = s_tvalid && s_tready;
    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            max_attempts_reg <= 8'd20;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                max_attempts_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= in_item;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    i2cseq_fsm #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .item         (in_item_reg),
        .max_attempts (max_attempts_reg),
        .res          (res)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_reg.action;
    assign m_tdata   = {6'd0, out_reg.byte_count, out_reg.done_res, out_reg.rx_byte,
                        out_reg.rx_valid, out_reg.tx_value};

    // a beat held in the input register is never dropped without advancing
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input beat lost");

    // every advanced beat produces a result beat in the next cycle
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result beat missing");

    // the result register is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("stalled result overwritten");

endmodule
